// ===== rtl/uwbs_pkg.sv =====
// Shared types and constants for the Unicode word boundary scanner.
package uwbs_pkg;

    localparam int LEN_W   = 16;
    localparam int OUT_W   = 16;
    localparam int MAX_OUT = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [4:0] {
        CL_CR    = 5'd0,
        CL_LF    = 5'd1,
        CL_NL    = 5'd2,
        CL_WS    = 5'd3,
        CL_AL    = 5'd4,
        CL_NU    = 5'd5,
        CL_ENL   = 5'd6,
        CL_HE    = 5'd7,
        CL_KA    = 5'd8,
        CL_RI    = 5'd9,
        CL_DQ    = 5'd10,
        CL_ML    = 5'd11,
        CL_MN    = 5'd12,
        CL_MNL   = 5'd13,
        CL_SQ    = 5'd14,
        CL_EXT   = 5'd15,
        CL_FMT   = 5'd16,
        CL_ZWJ   = 5'd17,
        CL_OTHER = 5'd18
    } class_t;

    typedef enum logic [9:0] {
        SC_START = 10'b00_0000_0001,
        SC_CR    = 10'b00_0000_0010,
        SC_WS    = 10'b00_0000_0100,
        SC_AL    = 10'b00_0000_1000,
        SC_HE    = 10'b00_0001_0000,
        SC_NU    = 10'b00_0010_0000,
        SC_KA    = 10'b00_0100_0000,
        SC_ENL   = 10'b00_1000_0000,
        SC_RI    = 10'b01_0000_0000,
        SC_ANY   = 10'b10_0000_0000
    } scan_t;

    typedef struct packed {
        scan_t  scan;
        len_t   open_len;
        len_t   pend_len;
        logic   pend_valid;
        class_t pend_class;
        logic   after_zwj;
        logic   pend_after_zwj;
    } ctx_t;

    typedef struct packed {
        ctx_t                    ctx;
        logic [1:0]              cnt;
        len_t [MAX_OUT-1:0]      len;
    } res_t;

    localparam ctx_t CTX_RESET = '{
        scan:           SC_START,
        open_len:       '0,
        pend_len:       '0,
        pend_valid:     1'b0,
        pend_class:     CL_CR,
        after_zwj:      1'b0,
        pend_after_zwj: 1'b0
    };

endpackage

// ===== rtl/unicode_word_boundary_scanner.sv =====
// Top level of the Unicode word boundary scanner: segment state and result queue.
//
//  Channel | Dir | Beat contents
//  --------+-----+------------------------------------------------------------
//  s_      | in  | tuser: break_class, is_pictographic; tdata: char_bytes;
//          |     | tlast: end_of_text
//  m_      | out | tdata: segment_bytes; tlast: last_of_run
//
// Each character is classified and folded into the segment state in the cycle it is
// accepted, and its finished segments (zero to three) enter a four-entry result queue.
// A character is taken whenever the queue holds at most one entry, so one character
// per cycle is sustained while each yields at most one segment and the output drains.
// Segments leave the queue one beat per cycle; a stalled output fills the queue and
// then holds off the input. Reset returns the scanner to the start state and empties
// the queue.
module unicode_word_boundary_scanner
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] char_bytes, [7:3] zero
    input  logic [5:0]  s_tuser,   // [4:0] break_class, [5] is_pictographic
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] segment_bytes
    output logic        m_tlast
);

    uwbs_pkg::ctx_t ctx_reg;
    uwbs_pkg::res_t res;
    uwbs_pkg::class_t in_class;

    logic [uwbs_pkg::OUT_W-1:0]   q_len_reg [uwbs_pkg::Q_DEPTH];
    logic                         q_last_reg [uwbs_pkg::Q_DEPTH];
    logic [uwbs_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [uwbs_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [uwbs_pkg::Q_CNT_W-1:0] q_cnt_reg;
    logic [uwbs_pkg::Q_CNT_W-1:0] q_cnt_next;
    logic [uwbs_pkg::Q_CNT_W-1:0] push_cnt;
    logic                         accept;
    logic                         pop;

    function automatic uwbs_pkg::len_t f_sat_add(uwbs_pkg::len_t a, uwbs_pkg::len_t b);
        logic [uwbs_pkg::LEN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[uwbs_pkg::LEN_W] ? '1 : sum[uwbs_pkg::LEN_W-1:0];
    endfunction

    function automatic logic [uwbs_pkg::OUT_W-1:0] f_out(uwbs_pkg::len_t l);
        logic [uwbs_pkg::LEN_W+uwbs_pkg::OUT_W-1:0] wide;
        wide = {{uwbs_pkg::OUT_W{1'b0}}, l};
        return (|wide[uwbs_pkg::LEN_W+uwbs_pkg::OUT_W-1:uwbs_pkg::OUT_W]) ?
               '1 : wide[uwbs_pkg::OUT_W-1:0];
    endfunction

    function automatic logic f_is_newline(uwbs_pkg::class_t c);
        return c == uwbs_pkg::CL_CR || c == uwbs_pkg::CL_LF || c == uwbs_pkg::CL_NL;
    endfunction

    function automatic uwbs_pkg::scan_t f_class_scan(uwbs_pkg::class_t c);
        uwbs_pkg::scan_t s;
        case (c)
            uwbs_pkg::CL_CR:  s = uwbs_pkg::SC_CR;
            uwbs_pkg::CL_WS:  s = uwbs_pkg::SC_WS;
            uwbs_pkg::CL_AL:  s = uwbs_pkg::SC_AL;
            uwbs_pkg::CL_NU:  s = uwbs_pkg::SC_NU;
            uwbs_pkg::CL_ENL: s = uwbs_pkg::SC_ENL;
            uwbs_pkg::CL_HE:  s = uwbs_pkg::SC_HE;
            uwbs_pkg::CL_KA:  s = uwbs_pkg::SC_KA;
            uwbs_pkg::CL_RI:  s = uwbs_pkg::SC_RI;
            default:          s = uwbs_pkg::SC_ANY;
        endcase
        return s;
    endfunction

    function automatic uwbs_pkg::res_t f_emit(uwbs_pkg::res_t r, uwbs_pkg::len_t l);
        uwbs_pkg::res_t o;
        o = r;
        if (r.cnt < 2'd3)
        begin
            o.len[r.cnt] = l;
            o.cnt = r.cnt + 2'd1;
        end
        return o;
    endfunction

    function automatic uwbs_pkg::res_t f_start_with(uwbs_pkg::res_t r, uwbs_pkg::class_t c,
                                                    logic [2:0] b);
        uwbs_pkg::res_t o;
        o = r;
        if (c == uwbs_pkg::CL_LF || c == uwbs_pkg::CL_NL)
        begin
            o = f_emit(o, uwbs_pkg::len_t'(b));
            o.ctx.open_len = '0;
            o.ctx.scan = uwbs_pkg::SC_START;
            o.ctx.after_zwj = 1'b0;
        end
        else
        begin
            o.ctx.open_len = uwbs_pkg::len_t'(b);
            o.ctx.scan = f_class_scan(c);
            o.ctx.after_zwj = (c == uwbs_pkg::CL_ZWJ);
        end
        return o;
    endfunction

    function automatic uwbs_pkg::res_t f_maybe_break(uwbs_pkg::res_t r, uwbs_pkg::class_t c,
                                                     logic pict, logic [2:0] b);
        uwbs_pkg::res_t o;
        o = r;
        if (r.ctx.after_zwj && pict && !f_is_newline(c))
        begin
            o.ctx.open_len = f_sat_add(r.ctx.open_len, uwbs_pkg::len_t'(b));
            o.ctx.scan = f_class_scan(c);
            o.ctx.after_zwj = (c == uwbs_pkg::CL_ZWJ);
        end
        else
        begin
            o = f_emit(o, r.ctx.open_len);
            o = f_start_with(o, c, b);
        end
        return o;
    endfunction

    function automatic uwbs_pkg::scan_t f_direct_join(uwbs_pkg::scan_t st, uwbs_pkg::class_t c);
        logic word;
        uwbs_pkg::scan_t t;
        word = (c == uwbs_pkg::CL_AL || c == uwbs_pkg::CL_HE ||
                c == uwbs_pkg::CL_NU || c == uwbs_pkg::CL_ENL);
        t = uwbs_pkg::SC_START;
        if (st == uwbs_pkg::SC_KA)
        begin
            if (c == uwbs_pkg::CL_KA || c == uwbs_pkg::CL_ENL)
                t = f_class_scan(c);
        end
        else if (st == uwbs_pkg::SC_ENL)
        begin
            if (word || c == uwbs_pkg::CL_KA)
                t = f_class_scan(c);
        end
        else if (st == uwbs_pkg::SC_AL || st == uwbs_pkg::SC_HE || st == uwbs_pkg::SC_NU)
        begin
            if (word)
                t = f_class_scan(c);
        end
        return t;
    endfunction

    function automatic logic f_may_pend(uwbs_pkg::scan_t st, uwbs_pkg::class_t c);
        logic p;
        p = 1'b0;
        if (st == uwbs_pkg::SC_AL)
            p = c == uwbs_pkg::CL_ML || c == uwbs_pkg::CL_MNL || c == uwbs_pkg::CL_SQ;
        else if (st == uwbs_pkg::SC_HE)
            p = c == uwbs_pkg::CL_ML || c == uwbs_pkg::CL_MNL || c == uwbs_pkg::CL_SQ ||
                c == uwbs_pkg::CL_DQ;
        else if (st == uwbs_pkg::SC_NU)
            p = c == uwbs_pkg::CL_MN || c == uwbs_pkg::CL_MNL || c == uwbs_pkg::CL_SQ;
        return p;
    endfunction

    function automatic logic f_pending_joins(uwbs_pkg::ctx_t s, uwbs_pkg::class_t c);
        logic j;
        j = 1'b0;
        if (s.scan == uwbs_pkg::SC_AL)
            j = c == uwbs_pkg::CL_AL || c == uwbs_pkg::CL_HE;
        else if (s.scan == uwbs_pkg::SC_HE)
        begin
            if (s.pend_class == uwbs_pkg::CL_DQ)
                j = c == uwbs_pkg::CL_HE;
            else
                j = c == uwbs_pkg::CL_AL || c == uwbs_pkg::CL_HE;
        end
        else if (s.scan == uwbs_pkg::SC_NU)
            j = c == uwbs_pkg::CL_NU;
        return j;
    endfunction

    function automatic uwbs_pkg::res_t f_pending_fail(uwbs_pkg::res_t r);
        uwbs_pkg::res_t o;
        o = r;
        if (r.ctx.scan == uwbs_pkg::SC_HE && r.ctx.pend_class == uwbs_pkg::CL_SQ)
            o.ctx.open_len = f_sat_add(r.ctx.open_len, r.ctx.pend_len);
        else
        begin
            o = f_emit(o, r.ctx.open_len);
            o.ctx.open_len = r.ctx.pend_len;
        end
        o.ctx.scan = uwbs_pkg::SC_ANY;
        o.ctx.after_zwj = r.ctx.pend_after_zwj;
        o.ctx.pend_valid = 1'b0;
        o.ctx.pend_len = '0;
        o.ctx.pend_class = uwbs_pkg::CL_CR;
        o.ctx.pend_after_zwj = 1'b0;
        return o;
    endfunction

    function automatic uwbs_pkg::res_t f_step(uwbs_pkg::ctx_t s, uwbs_pkg::class_t c,
                                              logic pict, logic [2:0] b, logic eot);
        uwbs_pkg::res_t  r;
        uwbs_pkg::len_t  bl;
        uwbs_pkg::scan_t t;
        logic            ext;
        r.ctx = s;
        r.cnt = 2'd0;
        r.len = '0;
        bl = uwbs_pkg::len_t'(b);
        t = f_direct_join(s.scan, c);
        ext = c == uwbs_pkg::CL_EXT || c == uwbs_pkg::CL_FMT || c == uwbs_pkg::CL_ZWJ;

        if (s.scan == uwbs_pkg::SC_START)
            r = f_start_with(r, c, b);
        else if (ext)
        begin
            if (s.scan == uwbs_pkg::SC_CR)
            begin
                r = f_emit(r, s.open_len);
                r = f_start_with(r, c, b);
            end
            else if (s.pend_valid)
            begin
                r.ctx.pend_len = f_sat_add(s.pend_len, bl);
                r.ctx.pend_after_zwj = (c == uwbs_pkg::CL_ZWJ);
            end
            else
            begin
                r.ctx.open_len = f_sat_add(s.open_len, bl);
                r.ctx.after_zwj = (c == uwbs_pkg::CL_ZWJ);
                if (s.scan == uwbs_pkg::SC_WS)
                    r.ctx.scan = uwbs_pkg::SC_ANY;
            end
        end
        else if (s.pend_valid)
        begin
            if (f_pending_joins(s, c))
            begin
                r.ctx.open_len = f_sat_add(f_sat_add(s.open_len, s.pend_len), bl);
                r.ctx.scan = f_class_scan(c);
                r.ctx.after_zwj = 1'b0;
                r.ctx.pend_valid = 1'b0;
                r.ctx.pend_len = '0;
                r.ctx.pend_class = uwbs_pkg::CL_CR;
                r.ctx.pend_after_zwj = 1'b0;
            end
            else
            begin
                r = f_pending_fail(r);
                r = f_maybe_break(r, c, pict, b);
            end
        end
        else if (s.scan == uwbs_pkg::SC_CR)
        begin
            if (c == uwbs_pkg::CL_LF)
            begin
                r = f_emit(r, f_sat_add(s.open_len, bl));
                r.ctx.open_len = '0;
                r.ctx.scan = uwbs_pkg::SC_START;
                r.ctx.after_zwj = 1'b0;
            end
            else
            begin
                r = f_emit(r, s.open_len);
                r = f_start_with(r, c, b);
            end
        end
        else if (s.scan == uwbs_pkg::SC_WS && c == uwbs_pkg::CL_WS)
            r.ctx.open_len = f_sat_add(s.open_len, bl);
        else if (s.scan == uwbs_pkg::SC_RI && c == uwbs_pkg::CL_RI)
        begin
            r.ctx.open_len = f_sat_add(s.open_len, bl);
            r.ctx.scan = uwbs_pkg::SC_ANY;
            r.ctx.after_zwj = 1'b0;
        end
        else if (t != uwbs_pkg::SC_START)
        begin
            r.ctx.open_len = f_sat_add(s.open_len, bl);
            r.ctx.scan = t;
            r.ctx.after_zwj = 1'b0;
        end
        else if (f_may_pend(s.scan, c))
        begin
            r.ctx.pend_valid = 1'b1;
            r.ctx.pend_len = bl;
            r.ctx.pend_class = c;
            r.ctx.pend_after_zwj = 1'b0;
        end
        else
            r = f_maybe_break(r, c, pict, b);

        if (eot)
        begin
            if (r.ctx.pend_valid)
                r = f_pending_fail(r);
            if (r.ctx.scan != uwbs_pkg::SC_START)
                r = f_emit(r, r.ctx.open_len);
            r.ctx = uwbs_pkg::CTX_RESET;
        end
        return r;
    endfunction

    // Classes beyond the defined range are handled as Other.
    assign in_class = (s_tuser[4:0] > uwbs_pkg::CL_OTHER) ? uwbs_pkg::CL_OTHER :
                      uwbs_pkg::class_t'(s_tuser[4:0]);

    always_comb
    begin
        res = f_step(ctx_reg, in_class, s_tuser[5], s_tdata[2:0], s_tlast);
    end

    assign s_tready = q_cnt_reg <= uwbs_pkg::Q_CNT_W'(1);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = q_cnt_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = q_len_reg[rd_ptr_reg];
    assign m_tlast  = q_last_reg[rd_ptr_reg];

    assign push_cnt   = accept ? uwbs_pkg::Q_CNT_W'(res.cnt) : '0;
    assign q_cnt_next = q_cnt_reg + push_cnt - uwbs_pkg::Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg    <= uwbs_pkg::CTX_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (accept)
                ctx_reg <= res.ctx;
            wr_ptr_reg <= wr_ptr_reg + uwbs_pkg::Q_PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + uwbs_pkg::Q_PTR_W'(pop);
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < uwbs_pkg::Q_DEPTH; j++)
        begin
            logic [uwbs_pkg::Q_PTR_W-1:0] off;
            off = uwbs_pkg::Q_PTR_W'(j) - wr_ptr_reg;
            if (accept && (uwbs_pkg::Q_CNT_W'(off) < uwbs_pkg::Q_CNT_W'(res.cnt)))
            begin
                q_len_reg[j]  <= f_out(res.len[off[1:0]]);
                q_last_reg[j] <= (uwbs_pkg::Q_CNT_W'(off) + uwbs_pkg::Q_CNT_W'(1)) ==
                                 uwbs_pkg::Q_CNT_W'(res.cnt);
            end
        end
    end

endmodule
